// ===== rtl/core/sc2c_pkg.sv =====
// shared types, constants and key tables of the scan code decoder
package sc2c_pkg;

    // scan code bytes
    localparam int unsigned CodeW = 8;
    localparam logic [CodeW-1:0] CodePrefix = 8'hE0;
    localparam logic [CodeW-1:0] CodeLShiftUp = 8'd170;
    localparam logic [CodeW-1:0] CodeRShiftUp = 8'd182;
    localparam logic [CodeW-1:0] CodeMakeMax = 8'd128;
    localparam logic [CodeW-1:0] CodeTabMax = 8'd83;
    localparam logic [CodeW-1:0] KeyAccent = 8'd40;
    localparam logic [CodeW-1:0] KeyLShift = 8'd42;
    localparam logic [CodeW-1:0] KeyRShift = 8'd54;
    localparam logic [CodeW-1:0] KeyCaps = 8'd58;
    localparam logic [CodeW-1:0] KeyNum = 8'd69;

    // lookup results: 8-bit character or one of two markers
    localparam int unsigned ResW = 9;
    localparam logic [ResW-1:0] NoChar = 9'h100;
    localparam logic [ResW-1:0] Unassigned = 9'h101;

    // led mask bits
    localparam logic [2:0] LedNum = 3'b010;
    localparam logic [2:0] LedCaps = 3'b100;

    // result kinds
    typedef enum logic [1:0] {
        KIND_NONE       = 2'd0,
        KIND_CHAR       = 2'd1,
        KIND_UNASSIGNED = 2'd2
    } kind_t;

    // keyboard flags kept in the state memory
    typedef struct packed {
        logic       ext;
        logic       lsh;
        logic       rsh;
        logic       caps;
        logic       num;
        logic       acc;
        logic [2:0] led;
    } kbd_state_t;

    localparam int unsigned StateW = $bits(kbd_state_t);
    localparam int unsigned StateDepth = 1;

    // widen a character to a lookup result
    function automatic logic [ResW-1:0] chr(input logic [7:0] c);
        return {1'b0, c};
    endfunction

    // plain layer, codes 1..83
    function automatic logic [ResW-1:0] plain_char(input logic [6:0] code);
        logic [ResW-1:0] v;
        case (code)
            7'd2:  v = chr("1");
            7'd3:  v = chr("2");
            7'd4:  v = chr("3");
            7'd5:  v = chr("4");
            7'd6:  v = chr("5");
            7'd7:  v = chr("6");
            7'd8:  v = chr("7");
            7'd9:  v = chr("8");
            7'd10: v = chr("9");
            7'd11: v = chr("0");
            7'd12: v = 9'd39;
            7'd13: v = 9'd168;
            7'd14: v = 9'd8;
            7'd15: v = 9'd9;
            7'd16: v = chr("q");
            7'd17: v = chr("w");
            7'd18: v = chr("e");
            7'd19: v = chr("r");
            7'd20: v = chr("t");
            7'd21: v = chr("y");
            7'd22: v = chr("u");
            7'd23: v = chr("i");
            7'd24: v = chr("o");
            7'd25: v = chr("p");
            7'd26: v = Unassigned;
            7'd27: v = chr("+");
            7'd28: v = 9'd10;
            7'd30: v = chr("a");
            7'd31: v = chr("s");
            7'd32: v = chr("d");
            7'd33: v = chr("f");
            7'd34: v = chr("g");
            7'd35: v = chr("h");
            7'd36: v = chr("j");
            7'd37: v = chr("k");
            7'd38: v = chr("l");
            7'd39: v = 9'd164;
            7'd40: v = chr("{");
            7'd41: v = chr("}");
            7'd42: v = 9'd124;
            7'd43: v = Unassigned;
            7'd44: v = chr("z");
            7'd45: v = chr("x");
            7'd46: v = chr("c");
            7'd47: v = chr("v");
            7'd48: v = chr("b");
            7'd49: v = chr("n");
            7'd50: v = chr("m");
            7'd51: v = chr(",");
            7'd52: v = chr(".");
            7'd53: v = chr("-");
            7'd54: v = Unassigned;
            7'd55: v = Unassigned;
            7'd57: v = chr(" ");
            7'd58: v = Unassigned;
            7'd69: v = chr("N");
            7'd70: v = chr("S");
            7'd71: v = chr("H");
            7'd72: v = 9'd202;
            7'd74: v = chr("-");
            7'd75: v = 9'd185;
            7'd76: v = 9'd206;
            7'd77: v = 9'd204;
            7'd78: v = chr("+");
            7'd79: v = chr("E");
            7'd80: v = 9'd203;
            7'd82: v = chr("I");
            7'd83: v = chr("D");
            default: v = NoChar;
        endcase
        return v;
    endfunction

    // shifted layer, codes 1..83
    function automatic logic [ResW-1:0] shift_char(input logic [6:0] code);
        logic [ResW-1:0] v;
        logic [ResW-1:0] p;
        p = plain_char(code);
        case (code)
            7'd2:  v = chr("!");
            7'd3:  v = chr("\"");
            7'd4:  v = chr("#");
            7'd5:  v = chr("$");
            7'd6:  v = chr("%");
            7'd7:  v = chr("&");
            7'd8:  v = chr("/");
            7'd9:  v = chr("(");
            7'd10: v = chr(")");
            7'd11: v = chr("=");
            7'd12: v = chr("?");
            7'd13: v = 9'd173;
            7'd27: v = chr("*");
            7'd39: v = 9'd165;
            7'd40: v = chr("[");
            7'd41: v = chr("]");
            7'd42: v = 9'd167;
            7'd51: v = chr(";");
            7'd52: v = chr(":");
            7'd53: v = chr("_");
            default:
            begin
                // letters go upper case, the rest matches the plain layer
                if (p inside {[chr("a"):chr("z")]})
                    v = p - 9'd32;
                else
                    v = p;
            end
        endcase
        return v;
    endfunction

    // numeric keypad digits, codes 71..83
    function automatic logic [ResW-1:0] keypad_char(input logic [6:0] code);
        logic [ResW-1:0] v;
        case (code)
            7'd71: v = chr("7");
            7'd72: v = chr("8");
            7'd73: v = chr("9");
            7'd75: v = chr("4");
            7'd76: v = chr("5");
            7'd77: v = chr("6");
            7'd79: v = chr("1");
            7'd80: v = chr("2");
            7'd81: v = chr("3");
            7'd82: v = chr("0");
            7'd83: v = chr(".");
            default: v = NoChar;
        endcase
        return v;
    endfunction

    // keys behind the extended prefix, codes 1..83
    function automatic logic [ResW-1:0] prefixed_char(input logic [6:0] code);
        logic [ResW-1:0] v;
        if (code == 7'd28)
            v = 9'd10;
        else if (code == 7'd53)
            v = chr("/");
        else if (code >= 7'd71 && code != 7'd78)
            v = plain_char(code);
        else
            v = NoChar;
        return v;
    endfunction

    function automatic logic is_letter(input logic [ResW-1:0] v);
        return (v inside {[chr("a"):chr("z")]}) || (v == 9'd164);
    endfunction

    function automatic logic is_keypad_digit(input logic [6:0] code);
        return code inside {[7'd71:7'd73], [7'd75:7'd77], [7'd79:7'd83]};
    endfunction

    // acute form of a plain vowel
    function automatic logic [ResW-1:0] acute_char(input logic [ResW-1:0] v);
        logic [ResW-1:0] a;
        case (v)
            chr("a"): a = 9'd160;
            chr("e"): a = 9'd130;
            chr("i"): a = 9'd161;
            chr("o"): a = 9'd162;
            chr("u"): a = 9'd163;
            default:  a = NoChar;
        endcase
        return a;
    endfunction

endpackage

// ===== rtl/core/sc2c_scan_if.sv =====
// scan code input channel
interface sc2c_scan_if;
    logic       valid;
    logic       ready;
    logic [7:0] scan_code;

    modport source (output valid, output scan_code, input ready);
    modport sink (input valid, input scan_code, output ready);
endinterface

// ===== rtl/core/sc2c_result_if.sv =====
// decoded character result channel
interface sc2c_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] char_code;
    logic       led_write;
    logic [2:0] led_bits;

    modport source (output valid, output kind, output char_code, output led_write,
                    output led_bits, input ready);
    modport sink (input valid, input kind, input char_code, input led_write,
                  input led_bits, output ready);
endinterface

// ===== rtl/core/sc2c_ram.sv =====
// generic single-write, single-read ram with registered read data
module sc2c_ram #(
    parameter int unsigned WIDTH = sc2c_pkg::StateW,
    parameter int unsigned DEPTH = sc2c_pkg::StateDepth,
    localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [AddrW-1:0]     wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic                 rd_en,
    input  logic [AddrW-1:0]     rd_addr,
    output logic [WIDTH-1:0]     rd_data
);
    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port, read returns old data on a collision
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

// ===== rtl/core/scancode_to_char_decoder_unit.sv =====
// scan code set 1 to character decoder, spanish layout
//
//  channel  | role   | payload
//  ---------+--------+---------------------------------------------
//  scan     | sink   | scan_code[7:0]
//  result   | source | kind[1:0] char_code[7:0] led_write led_bits[2:0]
//
// one item per cycle sustained while result.ready holds; a scan code goes from the
// state memory read to decode and write back into the output register
// the keyboard flags live in a one-entry state ram, a result written in the
// same cycle as the next read is forwarded to the following item
// rst_n clears the pipeline and marks the state entry unwritten, which reads as zero
// a stalled result holds the decode stage; scan.ready drops only while both are full
module scancode_to_char_decoder_unit (
    input  logic              clk,
    input  logic              rst_n,
    sc2c_scan_if.sink         scan,
    sc2c_result_if.source     result
);
    localparam int unsigned AddrW =
        (sc2c_pkg::StateDepth > 1) ? $clog2(sc2c_pkg::StateDepth) : 1;
    localparam logic [AddrW-1:0] StateAddr = '0;

    logic                           scan_acc;
    logic                           s1_move;
    logic                           out_free;
    logic                           s1_vld_reg;
    logic [sc2c_pkg::CodeW-1:0]     s1_code_reg;
    logic                           fwd_reg;
    logic                           rd_vld_reg;
    logic                           state_vld_reg;
    sc2c_pkg::kbd_state_t           fwd_state_reg;
    logic [sc2c_pkg::StateW-1:0]    rd_data;
    sc2c_pkg::kbd_state_t           cur_state;
    sc2c_pkg::kbd_state_t           nxt_state;
    logic [sc2c_pkg::ResW-1:0]      res;
    logic                           led_w;
    logic [6:0]                     idx;
    logic                           shift;
    logic [sc2c_pkg::ResW-1:0]      plain_v;
    logic [sc2c_pkg::ResW-1:0]      acute_v;
    sc2c_pkg::kind_t                kind_next;
    logic [7:0]                     char_next;
    logic                           out_vld_reg;
    sc2c_pkg::kind_t                out_kind_reg;
    logic [7:0]                     out_char_reg;
    logic                           out_led_w_reg;
    logic [2:0]                     out_led_reg;

    // handshake and pipeline advance
    assign out_free = !out_vld_reg || result.ready;
    assign s1_move = s1_vld_reg && out_free;
    assign scan.ready = !s1_vld_reg || s1_move;
    assign scan_acc = scan.valid && scan.ready;

    // state memory, read on accept and written when the decode stage retires
    sc2c_ram #(
        .WIDTH(sc2c_pkg::StateW),
        .DEPTH(sc2c_pkg::StateDepth)
    ) u_state_ram (
        .clk     (clk),
        .wr_en   (s1_move),
        .wr_addr (StateAddr),
        .wr_data (nxt_state),
        .rd_en   (scan_acc),
        .rd_addr (StateAddr),
        .rd_data (rd_data)
    );

    // decode stage control and forwarding flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            fwd_reg <= 1'b0;
            rd_vld_reg <= 1'b0;
            state_vld_reg <= 1'b0;
        end
        else
        begin
            if (s1_move)
            begin
                state_vld_reg <= 1'b1;
            end
            if (scan_acc)
            begin
                s1_vld_reg <= 1'b1;
                fwd_reg <= s1_move;
                rd_vld_reg <= state_vld_reg;
            end
            else if (s1_move)
            begin
                s1_vld_reg <= 1'b0;
            end
        end
    end

    // decode stage payload and the state being written alongside the read
    always_ff @(posedge clk)
    begin
        if (scan_acc)
        begin
            s1_code_reg <= scan.scan_code;
            fwd_state_reg <= nxt_state;
        end
    end

    // current flags: forwarded write, memory entry, or reset value
    always_comb
    begin
        if (fwd_reg)
            cur_state = fwd_state_reg;
        else if (rd_vld_reg)
            cur_state = sc2c_pkg::kbd_state_t'(rd_data);
        else
            cur_state = '0;
    end

    // flag update and table lookup
    always_comb
    begin
        idx = s1_code_reg[6:0];
        shift = cur_state.lsh || cur_state.rsh;
        plain_v = sc2c_pkg::plain_char(idx);
        acute_v = sc2c_pkg::acute_char(plain_v);
        nxt_state = cur_state;
        res = sc2c_pkg::NoChar;
        led_w = 1'b0;
        if (cur_state.ext)
        begin
            nxt_state.ext = 1'b0;
            if (s1_code_reg inside {[8'd1:sc2c_pkg::CodeTabMax]})
                res = sc2c_pkg::prefixed_char(idx);
        end
        else if (s1_code_reg == sc2c_pkg::CodePrefix)
        begin
            nxt_state.ext = 1'b1;
        end
        else if (s1_code_reg == sc2c_pkg::CodeLShiftUp)
        begin
            nxt_state.lsh = 1'b0;
        end
        else if (s1_code_reg == sc2c_pkg::CodeRShiftUp)
        begin
            nxt_state.rsh = 1'b0;
        end
        else if (s1_code_reg <= sc2c_pkg::CodeMakeMax)
        begin
            if (cur_state.acc)
            begin
                // dead key consumes this make code
                nxt_state.acc = 1'b0;
                if ((s1_code_reg inside {[8'd1:sc2c_pkg::CodeTabMax]}) &&
                    acute_v != sc2c_pkg::NoChar && !cur_state.caps && !shift)
                    res = acute_v;
            end
            else if (s1_code_reg == sc2c_pkg::KeyAccent)
            begin
                nxt_state.acc = 1'b1;
            end
            else if (s1_code_reg == sc2c_pkg::KeyLShift)
            begin
                nxt_state.lsh = 1'b1;
            end
            else if (s1_code_reg == sc2c_pkg::KeyRShift)
            begin
                nxt_state.rsh = 1'b1;
            end
            else if (s1_code_reg == sc2c_pkg::KeyCaps)
            begin
                nxt_state.led = cur_state.led ^ sc2c_pkg::LedCaps;
                nxt_state.caps = !cur_state.caps;
                led_w = 1'b1;
            end
            else if (s1_code_reg == sc2c_pkg::KeyNum)
            begin
                nxt_state.led = cur_state.led ^ sc2c_pkg::LedNum;
                nxt_state.num = !cur_state.num;
                led_w = 1'b1;
            end
            else if (s1_code_reg == 8'd0 || s1_code_reg > sc2c_pkg::CodeTabMax)
            begin
                res = sc2c_pkg::NoChar;
            end
            else if (cur_state.caps && sc2c_pkg::is_letter(plain_v))
            begin
                // shift undoes caps lock on letters
                res = shift ? plain_v : sc2c_pkg::shift_char(idx);
            end
            else if ((shift || cur_state.num) && sc2c_pkg::is_keypad_digit(idx))
            begin
                res = sc2c_pkg::keypad_char(idx);
            end
            else if (shift)
            begin
                res = sc2c_pkg::shift_char(idx);
            end
            else
            begin
                res = plain_v;
            end
        end
    end

    // result encoding
    always_comb
    begin
        if (res == sc2c_pkg::NoChar)
        begin
            kind_next = sc2c_pkg::KIND_NONE;
            char_next = 8'd0;
        end
        else if (res == sc2c_pkg::Unassigned)
        begin
            kind_next = sc2c_pkg::KIND_UNASSIGNED;
            char_next = 8'd0;
        end
        else
        begin
            kind_next = sc2c_pkg::KIND_CHAR;
            char_next = res[7:0];
        end
    end

    // output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_vld_reg <= s1_vld_reg;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_kind_reg <= kind_next;
            out_char_reg <= char_next;
            out_led_w_reg <= led_w;
            out_led_reg <= nxt_state.led;
        end
    end

    assign result.valid = out_vld_reg;
    assign result.kind = out_kind_reg;
    assign result.char_code = out_char_reg;
    assign result.led_write = out_led_w_reg;
    assign result.led_bits = out_led_reg;
endmodule

// ===== rtl/core/sc2c_checker.sv =====
// port-level checks of the scan code decoder and their bind
module sc2c_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] kind,
    input logic [7:0] char_code,
    input logic       led_write,
    input logic [2:0] led_bits
);
    // a stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(char_code) &&
        $stable(led_write) && $stable(led_bits))
        else $error("result item changed while stalled");

    // lock keys give no character
    a_led_no_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && led_write |-> kind == sc2c_pkg::KIND_NONE && char_code == 8'd0)
        else $error("led update carried a character");

    // scroll lock led never lit
    a_scroll_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !led_bits[0])
        else $error("scroll lock led set");

    // led mask changes only with an led update
    a_led_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready ##1 out_valid && !led_write |->
        led_bits == $past(led_bits))
        else $error("led mask changed without led update");

    // empty output means the pipeline can take an item
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");
endmodule

bind scancode_to_char_decoder_unit sc2c_checker u_sc2c_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (scan.valid),
    .in_ready  (scan.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .kind      (result.kind),
    .char_code (result.char_code),
    .led_write (result.led_write),
    .led_bits  (result.led_bits)
);
